FILE: rtl/toy_register_machine_execute_defines.svh
// assertion macros for the toy register machine execute block
// needs clk_i and rst_ni in the scope of the module that uses them
`ifndef TOY_REGISTER_MACHINE_EXECUTE_DEFINES_SVH
`define TOY_REGISTER_MACHINE_EXECUTE_DEFINES_SVH

// same-cycle implication, held off during reset
`define TRME_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define TRME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/trme_pkg.sv
// shared types and constants of the toy register machine execute block
// no dependencies
package trme_pkg;

  localparam int NumRegs   = 8;
  localparam int RegIdxW   = $clog2(NumRegs);
  localparam int DataW     = 32;
  localparam int RegFieldW = 8;
  localparam int DestW     = 16;

  typedef enum logic [2:0] {
    OpMov = 3'd0,
    OpAdd = 3'd1,
    OpMul = 3'd2,
    OpClt = 3'd3,
    OpJeq = 3'd4,
    OpJne = 3'd5,
    OpOut = 3'd6,
    OpNop = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    KindReg   = 2'd0,
    KindImm   = 2'd1,
    KindLbl   = 2'd2,
    KindOther = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    FlagNone  = 2'd0,
    FlagTrue  = 2'd1,
    FlagFalse = 2'd2
  } flag_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StNoReg = 2'd1,
    StBadOp = 2'd2,
    StStop  = 2'd3
  } status_e;

  // register file write port
  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] addr;
    logic [DataW-1:0]   data;
  } wr_t;

endpackage

FILE: rtl/trme_regfile.sv
// register file of the toy register machine: two registered read ports, one write port
// write-to-read bypass, per-entry valid bits so unwritten entries read as zero
// depends on trme_pkg
module trme_regfile
  import trme_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [RegIdxW-1:0] rd_addr_a_i,
  input  logic [RegIdxW-1:0] rd_addr_b_i,
  input  wr_t                wr_i,
  output logic [DataW-1:0]   rd_data_a_o,
  output logic [DataW-1:0]   rd_data_b_o
);

  logic [DataW-1:0]   mem [NumRegs];
  logic [NumRegs-1:0] vld_q;
  logic [DataW-1:0]   rd_a_q;
  logic [DataW-1:0]   rd_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // reads bypass a write landing on the same edge
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.addr == rd_addr_a_i)) begin
        rd_a_q <= wr_i.data;
      end else begin
        rd_a_q <= vld_q[rd_addr_a_i] ? mem[rd_addr_a_i] : '0;
      end
      if (wr_i.en && (wr_i.addr == rd_addr_b_i)) begin
        rd_b_q <= wr_i.data;
      end else begin
        rd_b_q <= vld_q[rd_addr_b_i] ? mem[rd_addr_b_i] : '0;
      end
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

FILE: rtl/toy_register_machine_execute.sv
// Toy register machine execute unit: takes one decoded instruction per beat and returns
// one result beat per instruction, through an input register with register file read,
// then execute into the result register; throughput is one instruction per cycle
// unless the result channel stalls, set by the single execute stage that reads and
// writes the register file, the compare flag and the stop bit in the same cycle. Register
// reads are bypassed from the write of the instruction ahead, so back-to-back dependent
// instructions see fresh values. A bad operand kind or register index reports an error
// and stops the machine; every later beat then reports stopped until reset. Depends on
// trme_pkg, trme_regfile and toy_register_machine_execute_defines.svh.
`include "toy_register_machine_execute_defines.svh"

module toy_register_machine_execute
  import trme_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // instruction channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              operation_i,
  input  logic [1:0]              first_kind_i,
  input  logic [RegFieldW-1:0]    first_reg_i,
  input  logic signed [DataW-1:0] first_imm_i,
  input  logic [1:0]              second_kind_i,
  input  logic [RegFieldW-1:0]    second_reg_i,
  input  logic signed [DataW-1:0] second_imm_i,
  input  logic [DestW-1:0]        jump_dest_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic                    print_valid_o,
  output logic signed [DataW-1:0] print_value_o,
  output logic                    jump_taken_o,
  output logic [DestW-1:0]        jump_to_o
);

  typedef struct packed {
    op_e                  op;
    kind_e                k1;
    logic [RegFieldW-1:0] r1;
    logic [DataW-1:0]     i1;
    kind_e                k2;
    logic [RegFieldW-1:0] r2;
    logic [DataW-1:0]     i2;
    logic [DestW-1:0]     dest;
  } instr_t;

  typedef struct packed {
    status_e          status;
    logic             pv;
    logic [DataW-1:0] pval;
    logic             jt;
    logic [DestW-1:0] jto;
  } res_t;

  // handshake and pipeline control
  logic   s1_vld_q;
  instr_t s1_q;
  logic   out_vld_q;
  res_t   out_q;
  res_t   res_d;
  logic   out_ready;
  logic   s1_adv;
  logic   in_acc;

  // architectural state
  flag_e  flag_q, flag_d;
  logic   stopped_q, stopped_d;

  // register file
  wr_t              wr;
  logic [DataW-1:0] rd_a;
  logic [DataW-1:0] rd_b;

  // operand decode
  logic             r1_bad;
  logic             r2_bad;
  logic             k1_val;
  logic             k2_val;
  logic [DataW-1:0] opa;
  logic [DataW-1:0] opb;
  logic [DataW-1:0] sum;
  logic [DataW-1:0] prod;
  logic             less;

  // result register frees up when empty or when its beat leaves
  assign out_ready  = !out_vld_q || !out_stall_i;
  assign s1_adv     = s1_vld_q && out_ready;
  assign in_stall_o = s1_vld_q && !out_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  // cleared in reset so the decoder never sees an unknown opcode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (in_acc) begin
      s1_q.op   <= op_e'(operation_i);
      s1_q.k1   <= kind_e'(first_kind_i);
      s1_q.r1   <= first_reg_i;
      s1_q.i1   <= first_imm_i;
      s1_q.k2   <= kind_e'(second_kind_i);
      s1_q.r2   <= second_reg_i;
      s1_q.i2   <= second_imm_i;
      s1_q.dest <= jump_dest_i;
    end
  end

  // operands are read as the beat enters the input register
  trme_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_acc),
    .rd_addr_a_i (first_reg_i[RegIdxW-1:0]),
    .rd_addr_b_i (second_reg_i[RegIdxW-1:0]),
    .wr_i        (wr),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b)
  );

  // operand selection and arithmetic
  assign r1_bad = s1_q.r1 >= RegFieldW'(NumRegs);
  assign r2_bad = s1_q.r2 >= RegFieldW'(NumRegs);
  assign k1_val = (s1_q.k1 == KindReg) || (s1_q.k1 == KindImm);
  assign k2_val = (s1_q.k2 == KindReg) || (s1_q.k2 == KindImm);
  assign opa    = (s1_q.k1 == KindReg) ? rd_a : s1_q.i1;
  assign opb    = (s1_q.k2 == KindReg) ? rd_b : s1_q.i2;
  assign sum    = opa + opb;
  assign prod   = opa * opb;
  // signed less-than by flipping the sign bits
  assign less   = {~opa[DataW-1], opa[DataW-2:0]} < {~opb[DataW-1], opb[DataW-2:0]};

  // execute: one instruction against the current state
  always_comb begin
    res_d     = '{status: StOk, pv: 1'b0, pval: '0, jt: 1'b0, jto: '0};
    wr        = '{en: 1'b0, addr: s1_q.r1[RegIdxW-1:0], data: '0};
    flag_d    = flag_q;
    if (stopped_q) begin
      res_d.status = StStop;
    end else begin
      unique case (s1_q.op)
        OpMov, OpAdd, OpMul: begin
          if ((s1_q.k1 != KindReg) || !k2_val) begin
            res_d.status = StBadOp;
          end else if (r1_bad || ((s1_q.k2 == KindReg) && r2_bad)) begin
            res_d.status = StNoReg;
          end else begin
            wr.en = 1'b1;
            case (s1_q.op)
              OpMov:   wr.data = opb;
              OpAdd:   wr.data = sum;
              default: wr.data = prod;
            endcase
          end
        end
        OpClt: begin
          if (!k1_val || !k2_val) begin
            res_d.status = StBadOp;
          end else if (((s1_q.k1 == KindReg) && r1_bad) ||
                       ((s1_q.k2 == KindReg) && r2_bad)) begin
            res_d.status = StNoReg;
          end else begin
            flag_d = less ? FlagTrue : FlagFalse;
          end
        end
        OpJeq, OpJne: begin
          if (s1_q.k1 != KindLbl) begin
            res_d.status = StBadOp;
          end else begin
            if (((s1_q.op == OpJeq) && (flag_q == FlagTrue)) ||
                ((s1_q.op == OpJne) && (flag_q == FlagFalse))) begin
              res_d.jt  = 1'b1;
              res_d.jto = s1_q.dest;
            end
            flag_d = FlagNone;
          end
        end
        OpOut: begin
          if (!k1_val) begin
            res_d.status = StBadOp;
          end else if ((s1_q.k1 == KindReg) && r1_bad) begin
            res_d.status = StNoReg;
          end else begin
            res_d.pv   = 1'b1;
            res_d.pval = opa;
          end
        end
        OpNop: begin
        end
        default: begin
        end
      endcase
    end
    // only a beat that actually leaves the input register touches state
    if (!s1_adv) begin
      wr.en  = 1'b0;
      flag_d = flag_q;
    end
    stopped_d = stopped_q ||
                (s1_adv && ((res_d.status == StNoReg) || (res_d.status == StBadOp)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q    <= FlagNone;
      stopped_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      flag_q    <= flag_d;
      stopped_q <= stopped_d;
      if (out_ready) begin
        out_vld_q <= s1_adv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_o      = out_q.status;
  assign print_valid_o = out_q.pv;
  assign print_value_o = out_q.pval;
  assign jump_taken_o  = out_q.jt;
  assign jump_to_o     = out_q.jto;

  // stop is sticky until reset
  `TRME_ASSERT_NEXT(a_stop_sticky, stopped_q, stopped_q, "stop bit cleared without reset")
  // a stopped machine reports stopped for the next beat it executes
  `TRME_ASSERT_NEXT(a_stop_reports, s1_adv && stopped_q, out_vld_q && (out_q.status == StStop),
    "stopped machine did not report stopped")
  // jumps and prints only come from instructions that completed cleanly
  `TRME_ASSERT_IMPL(a_side_ok, out_vld_q && (out_q.jt || out_q.pv), out_q.status == StOk,
    "jump or print on a failed instruction")
  // no register write once stopped
  `TRME_ASSERT_IMPL(a_no_wr_stopped, stopped_q, !wr.en, "register write while stopped")

endmodule

FILE: tb/sv/tb_toy_register_machine_execute.sv
// testbench for toy_register_machine_execute: drives decoded instructions with
// random gaps and stalls, predicts every result beat in a scoreboard class.
// depends on trme_pkg and the toy_register_machine_execute rtl
module tb_toy_register_machine_execute;
  timeunit 1ns;
  timeprecision 1ps;

  import trme_pkg::*;

  // hard stop, far above the slowest legal run
  localparam int unsigned CycleLimit = 600000;
  localparam int RandomInstrs = 1200;
  localparam int HaltedInstrs = 20;

  // one instruction beat, field for field as on the ports
  typedef struct packed {
    op_e                  op;
    kind_e                first_kind;
    logic [RegFieldW-1:0] first_reg;
    logic [DataW-1:0]     first_imm;
    kind_e                second_kind;
    logic [RegFieldW-1:0] second_reg;
    logic [DataW-1:0]     second_imm;
    logic [DestW-1:0]     jump_dest;
  } instr_t;

  // one result beat
  typedef struct packed {
    logic [1:0]       status;
    logic             print_valid;
    logic [DataW-1:0] print_value;
    logic             jump_taken;
    logic [DestW-1:0] jump_to;
  } result_t;

  // machine state mirror plus the queue of results still owed by the block
  class exec_scoreboard;
    logic [DataW-1:0] regs [NumRegs];
    flag_e            flag;
    bit               halted;
    result_t          expected_results[$];
    int               error_count;

    function new();
      foreach (regs[i]) regs[i] = '0;
      flag        = FlagNone;
      halted      = 1'b0;
      error_count = 0;
    endfunction

    // register or immediate operand; 0 when the register index is out of range
    function bit read_operand(kind_e kind, logic [RegFieldW-1:0] idx,
                              logic [DataW-1:0] imm, output logic [DataW-1:0] val);
      val = imm;
      if (kind == KindReg) begin
        if (idx >= NumRegs) return 1'b0;
        val = regs[idx[RegIdxW-1:0]];
      end
      return 1'b1;
    endfunction

    function bit is_value(kind_e kind);
      return kind == KindReg || kind == KindImm;
    endfunction

    // execute one accepted beat on the mirror and queue what the block must answer
    function void note_instr(instr_t t);
      result_t          r;
      logic [DataW-1:0] a;
      logic [DataW-1:0] b;
      bit               a_ok;
      bit               b_ok;
      r = '0;
      r.status = StOk;
      a = '0;
      b = '0;
      if (halted) begin
        r.status = StStop;
      end else begin
        case (t.op)
          OpMov, OpAdd, OpMul: begin
            if (t.first_kind != KindReg || !is_value(t.second_kind)) begin
              r.status = StBadOp;
            end else begin
              a_ok = read_operand(t.first_kind, t.first_reg, t.first_imm, a);
              b_ok = read_operand(t.second_kind, t.second_reg, t.second_imm, b);
              if (!a_ok || !b_ok) r.status = StNoReg;
              else if (t.op == OpMov) regs[t.first_reg[RegIdxW-1:0]] = b;
              else if (t.op == OpAdd) regs[t.first_reg[RegIdxW-1:0]] = a + b;
              else regs[t.first_reg[RegIdxW-1:0]] = a * b;
            end
          end
          OpClt: begin
            if (!is_value(t.first_kind) || !is_value(t.second_kind)) begin
              r.status = StBadOp;
            end else begin
              a_ok = read_operand(t.first_kind, t.first_reg, t.first_imm, a);
              b_ok = read_operand(t.second_kind, t.second_reg, t.second_imm, b);
              if (!a_ok || !b_ok) r.status = StNoReg;
              else flag = ($signed(a) < $signed(b)) ? FlagTrue : FlagFalse;
            end
          end
          OpJeq, OpJne: begin
            if (t.first_kind != KindLbl) begin
              r.status = StBadOp;
            end else begin
              if ((t.op == OpJeq && flag == FlagTrue) || (t.op == OpJne && flag == FlagFalse)) begin
                r.jump_taken = 1'b1;
                r.jump_to    = t.jump_dest;
              end
              flag = FlagNone;
            end
          end
          OpOut: begin
            if (!is_value(t.first_kind)) begin
              r.status = StBadOp;
            end else if (!read_operand(t.first_kind, t.first_reg, t.first_imm, a)) begin
              r.status = StNoReg;
            end else begin
              r.print_valid = 1'b1;
              r.print_value = a;
            end
          end
          default: ;
        endcase
      end
      if (r.status == StNoReg || r.status == StBadOp) halted = 1'b1;
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void compare_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        error_count++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with no instruction outstanding", $time);
        error_count++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("print_valid", want.print_valid, got.print_valid);
      compare_field("print_value", want.print_value, got.print_value);
      compare_field("jump_taken", want.jump_taken, got.jump_taken);
      compare_field("jump_to", want.jump_to, got.jump_to);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        out_stall = 1'b0;
  instr_t      drv       = '0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  status;
  logic        print_valid;
  logic [DataW-1:0] print_value;
  logic        jump_taken;
  logic [DestW-1:0] jump_to;

  int unsigned     cycles     = 0;
  int              burst_left = 0;
  exec_scoreboard  sb;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  toy_register_machine_execute i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (drv.op),
    .first_kind_i  (drv.first_kind),
    .first_reg_i   (drv.first_reg),
    .first_imm_i   (drv.first_imm),
    .second_kind_i (drv.second_kind),
    .second_reg_i  (drv.second_reg),
    .second_imm_i  (drv.second_imm),
    .jump_dest_i   (drv.jump_dest),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .print_valid_o (print_valid),
    .print_value_o (print_value),
    .jump_taken_o  (jump_taken),
    .jump_to_o     (jump_to)
  );

  // immediates lean on the corners of the signed range
  function automatic logic [DataW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [RegFieldW-1:0] good_reg();
    return RegFieldW'($urandom_range(0, NumRegs - 1));
  endfunction

  function automatic instr_t build_instr(op_e op, kind_e k1, logic [RegFieldW-1:0] r1,
                                         logic [DataW-1:0] i1, kind_e k2,
                                         logic [RegFieldW-1:0] r2, logic [DataW-1:0] i2,
                                         logic [DestW-1:0] dest);
    instr_t t;
    t = '{op, k1, r1, i1, k2, r2, i2, dest};
    return t;
  endfunction

  // every field random first, then the used operands made legal; unused fields
  // keep full-range noise so each port bit toggles without stopping the machine
  function automatic instr_t rand_good_instr();
    instr_t t;
    int     pick;
    t.first_kind  = kind_e'($urandom_range(0, 3));
    t.first_reg   = RegFieldW'($urandom_range(0, 255));
    t.first_imm   = rand_word();
    t.second_kind = kind_e'($urandom_range(0, 3));
    t.second_reg  = RegFieldW'($urandom_range(0, 255));
    t.second_imm  = rand_word();
    t.jump_dest   = DestW'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 15) t.op = OpMov;
    else if (pick < 30) t.op = OpAdd;
    else if (pick < 40) t.op = OpMul;
    else if (pick < 60) t.op = OpClt;
    else if (pick < 72) t.op = OpJeq;
    else if (pick < 84) t.op = OpJne;
    else if (pick < 94) t.op = OpOut;
    else t.op = OpNop;
    case (t.op)
      OpMov, OpAdd, OpMul: begin
        t.first_kind  = KindReg;
        t.first_reg   = good_reg();
        t.second_kind = kind_e'($urandom_range(0, 1));
        if (t.second_kind == KindReg) t.second_reg = good_reg();
      end
      OpClt: begin
        t.first_kind  = kind_e'($urandom_range(0, 1));
        t.second_kind = kind_e'($urandom_range(0, 1));
        if (t.first_kind == KindReg) t.first_reg = good_reg();
        if (t.second_kind == KindReg) t.second_reg = good_reg();
      end
      OpJeq, OpJne: t.first_kind = KindLbl;
      OpOut: begin
        t.first_kind = kind_e'($urandom_range(0, 1));
        if (t.first_kind == KindReg) t.first_reg = good_reg();
      end
      default: ;
    endcase
    return t;
  endfunction

  // mostly back to back, some short gaps, a few long ones, and idle-free bursts
  function automatic int pick_gap();
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // present one beat after some idle cycles and hold it until it is taken
  task automatic issue_instr(instr_t t, int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    drv      <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_instr(t);
  endtask

  // result side back-pressure: long open stretches, short and long stalls
  initial begin
    int hold;
    int pick;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          out_stall <= 1'b0;
          hold = $urandom_range(0, 25);
        end else if (pick < 90) begin
          out_stall <= 1'b1;
          hold = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          hold = $urandom_range(8, 30);
        end
      end
    end
  end

  // every accepted result beat goes to the scoreboard
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{status, print_valid, print_value, jump_taken, jump_to};
      sb.check_result(got);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("toy_register_machine_execute regression: fail");
      $finish;
    end
  end

  initial begin
    instr_t t;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: range corners, wrap of add and mul, back-to-back dependent
    // writes, jeq against every flag value and jne against none and false, flag kept across
    // other instructions and cleared by a jump, nop with every field at ones
    issue_instr(build_instr(OpMov, KindReg, 0, 0, KindImm, 0, 32'h7fff_ffff, 0), 0);
    issue_instr(build_instr(OpMov, KindReg, 7, 0, KindImm, 0, 32'h8000_0000, 0), 0);
    issue_instr(build_instr(OpOut, KindReg, 0, 0, KindReg, 255, 0, 0), 0);
    issue_instr(build_instr(OpOut, KindReg, 7, 0, KindReg, 0, 0, 0), 0);
    issue_instr(build_instr(OpAdd, KindReg, 0, 0, KindReg, 7, 0, 0), 0);
    issue_instr(build_instr(OpAdd, KindReg, 0, 0, KindImm, 0, 32'd1, 0), 0);
    issue_instr(build_instr(OpOut, KindReg, 0, 0, KindImm, 0, 0, 0), 0);
    issue_instr(build_instr(OpMov, KindReg, 1, 0, KindImm, 0, 32'hffff_ffff, 0), 0);
    issue_instr(build_instr(OpMul, KindReg, 1, 0, KindReg, 1, 0, 0), 0);
    issue_instr(build_instr(OpMul, KindReg, 7, 0, KindImm, 0, 32'd2, 0), 0);
    issue_instr(build_instr(OpMul, KindReg, 1, 0, KindImm, 0, 32'h8000_0000, 0), 0);
    issue_instr(build_instr(OpOut, KindReg, 1, 0, KindImm, 0, 0, 0), 0);
    issue_instr(build_instr(OpJeq, KindLbl, 0, 0, KindReg, 0, 0, 16'hffff), 0);
    issue_instr(build_instr(OpMov, KindReg, 2, 0, KindImm, 0, 32'h8000_0000, 0), 0);
    issue_instr(build_instr(OpClt, KindReg, 2, 0, KindImm, 0, 32'h7fff_ffff, 0), 0);
    issue_instr(build_instr(OpOut, KindImm, 0, 32'h8000_0000, KindReg, 0, 0, 0), 0);
    issue_instr(build_instr(OpJeq, KindLbl, 0, 0, KindLbl, 0, 0, 16'hffff), 0);
    issue_instr(build_instr(OpJeq, KindLbl, 0, 0, KindLbl, 0, 0, 16'hffff), 0);
    issue_instr(build_instr(OpClt, KindImm, 0, 32'h7fff_ffff, KindReg, 2, 0, 0), 0);
    issue_instr(build_instr(OpJne, KindLbl, 0, 0, KindOther, 0, 0, 16'h0000), 0);
    issue_instr(build_instr(OpClt, KindImm, 0, 32'd5, KindImm, 0, 32'd5, 0), 0);
    issue_instr(build_instr(OpJeq, KindLbl, 0, 0, KindImm, 0, 0, 16'h1234), 0);
    issue_instr(build_instr(OpJne, KindLbl, 0, 0, KindImm, 0, 0, 16'h4321), 0);
    issue_instr(build_instr(OpNop, KindOther, 255, '1, KindOther, 255, '1, 16'hffff), 0);
    issue_instr(build_instr(OpMov, KindReg, 3, 0, KindReg, 2, 0, 0), 0);

    // random legal programs: the stop bit is sticky until reset, so errors wait
    for (int n = 0; n < RandomInstrs; n++) issue_instr(rand_good_instr(), pick_gap());

    // a single fault of a random kind stops the machine
    t = rand_good_instr();
    case ($urandom_range(0, 6))
      0: begin
        t.op         = OpMov;
        t.first_kind = KindImm;
      end
      1: begin
        t.op          = OpAdd;
        t.first_kind  = KindReg;
        t.first_reg   = RegFieldW'($urandom_range(NumRegs, 255));
        t.second_kind = KindImm;
      end
      2: begin
        t.op          = OpMul;
        t.first_kind  = KindReg;
        t.first_reg   = good_reg();
        t.second_kind = KindReg;
        t.second_reg  = RegFieldW'($urandom_range(NumRegs, 255));
      end
      3: begin
        t.op         = OpClt;
        t.first_kind = kind_e'($urandom_range(2, 3));
      end
      4: begin
        t.op         = OpJne;
        t.first_kind = kind_e'($urandom_range(0, 2));
        if (t.first_kind == KindLbl) t.first_kind = KindOther;
      end
      5: begin
        t.op         = OpOut;
        t.first_kind = KindReg;
        t.first_reg  = RegFieldW'($urandom_range(NumRegs, 255));
      end
      default: begin
        // kind check wins over a bad register index
        t.op          = OpClt;
        t.first_kind  = KindReg;
        t.first_reg   = RegFieldW'($urandom_range(NumRegs, 255));
        t.second_kind = KindOther;
      end
    endcase
    issue_instr(t, pick_gap());

    // anything after the fault must report stopped
    for (int n = 0; n < HaltedInstrs; n++) begin
      t = '{op_e'($urandom_range(0, 7)), kind_e'($urandom_range(0, 3)),
            RegFieldW'($urandom_range(0, 255)), rand_word(), kind_e'($urandom_range(0, 3)),
            RegFieldW'($urandom_range(0, 255)), rand_word(), DestW'($urandom())};
      issue_instr(t, pick_gap());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then keep watching to catch stray beats
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("toy_register_machine_execute regression: pass");
    end else begin
      $display("toy_register_machine_execute regression: fail");
    end
    $finish;
  end

endmodule
